[hdl/sgr_pkg.sv]
// Shared constants for the softmax gradient row block: field widths and
// fixed-point formats of the Q3.12 datapath. No dependencies.
`default_nettype none

package sgr_pkg;

  localparam int MAX_COLS_DEF = 64;

  localparam int GRAD_W = 16;
  localparam int PROB_W = 13;
  localparam int PREV_W = 16;
  localparam int FRAC_W = 12;

  // dot accumulator, Q.24
  localparam int ACC_W  = 40;
  // (grad << 12) - dot stays below 2^35 in magnitude
  localparam int DIFF_W = 37;
  // diff * prob stays below 2^48 in magnitude, Q.36
  localparam int PROD_W = 50;
  // rounded term, Q.12
  localparam int TERM_W = PROD_W - 2 * FRAC_W;
  localparam int SUM_W  = TERM_W + 1;

  localparam int ELEM_W = GRAD_W + PROB_W + PREV_W;

  localparam int JOBQ_DEPTH = 2;

  localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (2 * FRAC_W - 1);

endpackage

`default_nettype wire

[hdl/sgr_in_if.sv]
// Input and result channels of the softmax gradient row block.
// Depends on sgr_pkg for field widths.
`default_nettype none

interface sgr_in_if import sgr_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [GRAD_W-1:0] grad_elem;
  logic        [PROB_W-1:0] prob_elem;
  logic signed [PREV_W-1:0] prev_elem;
  logic                     row_last;

  modport source(output valid, grad_elem, prob_elem, prev_elem, row_last, input ready);
  modport sink(input valid, grad_elem, prob_elem, prev_elem, row_last, output ready);
endinterface

interface sgr_out_if import sgr_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [PREV_W-1:0] new_grad;
  logic                     sat_flag;
  logic                     out_last;

  modport source(output valid, new_grad, sat_flag, out_last, input ready);
  modport sink(input valid, new_grad, sat_flag, out_last, output ready);
endinterface

`default_nettype wire

[hdl/sgr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module sgr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[hdl/sgr_job_q.sv]
// Short queue of closed-row jobs between the front and back parts.
// No dependencies.
`default_nettype none

module sgr_job_q #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output      logic             not_empty,
  output      logic [WIDTH-1:0] pop_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CNTW-1:0]  fill;

  logic do_push;
  logic do_pop;

  assign not_empty = (fill != '0);
  assign pop_data  = slots[rd_ptr];
  assign do_push   = push && (fill != CNTW'(DEPTH));
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      fill <= fill + CNTW'(do_push) - CNTW'(do_pop);
    end
  end

endmodule

`default_nettype wire

[hdl/sgr_front.sv]
// Front part: accepts elements, writes them into the row buffer bank being
// filled, accumulates grad*prob and queues a job when a row closes.
// Depends on sgr_pkg and sgr_in_if.
`default_nettype none

module sgr_front import sgr_pkg::*; #(
  parameter int MAX_COLS = MAX_COLS_DEF,
  parameter int CW       = $clog2(MAX_COLS),
  parameter int AW       = CW + 1
) (
  input  wire logic         clk,
  input  wire logic         rst,
  sgr_in_if.sink            din,
  input  wire logic         release_row,
  output      logic         ram_we,
  output      logic [AW-1:0] ram_waddr,
  output      logic [ELEM_W-1:0] ram_wdata,
  output      logic         q_push,
  output      logic [ACC_W-1:0] q_dot,
  output      logic         q_bank,
  output      logic [CW-1:0] q_last_idx
);

  localparam int MUL_W = GRAD_W + PROB_W + 1;

  logic [1:0]    busy;
  logic [1:0]    busy_next;
  logic [CW-1:0] count;
  logic          fill_bank;
  logic signed [ACC_W-1:0] acc;

  logic          pv;
  logic          pclose;
  logic [CW-1:0] pidx;
  logic          pbank;
  logic signed [MUL_W-1:0] prod_r;

  logic accept;
  logic close;
  logic signed [MUL_W-1:0] prod_c;
  logic signed [ACC_W-1:0] acc_sum;

  assign din.ready = (busy != 2'd2);
  assign accept    = din.valid && din.ready;
  assign close     = din.row_last || (count == CW'(MAX_COLS - 1));

  assign ram_we    = accept;
  assign ram_waddr = {fill_bank, count};
  assign ram_wdata = {din.grad_elem, din.prob_elem, din.prev_elem};

  assign prod_c  = MUL_W'(din.grad_elem) * MUL_W'($signed({1'b0, din.prob_elem}));
  assign acc_sum = acc + ACC_W'(prod_r);

  assign q_push     = pv && pclose;
  assign q_dot      = acc_sum;
  assign q_bank     = pbank;
  assign q_last_idx = pidx;

  // a bank counts as busy from its closing element until the back part
  // has issued its last read
  always_comb begin
    busy_next = busy;
    if (accept && close && !release_row) begin
      busy_next = busy + 2'd1;
    end else if (release_row && !(accept && close)) begin
      busy_next = busy - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_c;
    pidx   <= count;
    pbank  <= fill_bank;
    if (rst) begin
      busy      <= '0;
      count     <= '0;
      fill_bank <= 1'b0;
      acc       <= '0;
      pv        <= 1'b0;
      pclose    <= 1'b0;
    end else begin
      busy   <= busy_next;
      pv     <= accept;
      pclose <= accept && close;
      if (accept) begin
        if (close) begin
          count     <= '0;
          fill_bank <= ~fill_bank;
        end else begin
          count <= count + CW'(1);
        end
      end
      if (pv) begin
        acc <= pclose ? '0 : acc_sum;
      end
    end
  end

`ifndef ASSERT_OFF
  a_busy_range: assert property (@(posedge clk) disable iff (rst)
    busy != 2'd3)
    else $error("row bank busy count out of range");

  a_push_follows_close: assert property (@(posedge clk) disable iff (rst)
    accept && close |=> q_push)
    else $error("closed row not queued");

  a_count_restart: assert property (@(posedge clk) disable iff (rst)
    accept && close |=> count == '0)
    else $error("element count not restarted after row close");
`endif

endmodule

`default_nettype wire

[hdl/sgr_back.sv]
// Back part: takes a row job, reads its elements back from the row buffer
// and runs prev + (grad - dot) * prob through a stalling pipeline.
// Depends on sgr_pkg and sgr_out_if.
`default_nettype none

module sgr_back import sgr_pkg::*; #(
  parameter int CW = 6,
  parameter int AW = CW + 1
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              q_valid,
  input  wire logic [ACC_W-1:0]  q_dot,
  input  wire logic              q_bank,
  input  wire logic [CW-1:0]     q_last_idx,
  output      logic              q_pop,
  output      logic              release_row,
  output      logic              ram_re,
  output      logic [AW-1:0]     ram_raddr,
  input  wire logic [ELEM_W-1:0] ram_rdata,
  sgr_out_if.source              dout
);

  localparam int PMUL_W = DIFF_W + PROB_W + 1;

  typedef enum logic {S_IDLE, S_RUN} state_t;

  state_t        state;
  logic          bank;
  logic [CW-1:0] last_idx;
  logic [CW-1:0] k;
  logic signed [ACC_W-1:0] dot;

  // stage 1: read data
  logic                    v1;
  logic                    last1;
  logic signed [ACC_W-1:0] dot1;
  // stage 2: difference
  logic                     v2;
  logic                     last2;
  logic signed [DIFF_W-1:0] diff2;
  logic        [PROB_W-1:0] prob2;
  logic signed [PREV_W-1:0] prev2;
  // stage 3: product
  logic                     v3;
  logic                     last3;
  logic signed [PROD_W-1:0] prod3;
  logic signed [PREV_W-1:0] prev3;
  // stage 4: rounded term
  logic                     v4;
  logic                     last4;
  logic signed [TERM_W-1:0] term4;
  logic signed [PREV_W-1:0] prev4;

  logic adv;
  logic issue;
  logic signed [GRAD_W-1:0] r_grad;
  logic        [PROB_W-1:0] r_prob;
  logic signed [PREV_W-1:0] r_prev;
  logic signed [ACC_W-1:0]  diff_c;
  logic signed [PMUL_W-1:0] prod_c;
  logic signed [PROD_W-1:0] rnd_c;
  logic signed [SUM_W-1:0]  sum_c;
  logic [SUM_W-PREV_W:0]    sum_hi;
  logic                     ovf;
  logic signed [PREV_W-1:0] sat_val;

  assign adv         = !dout.valid || dout.ready;
  assign issue       = (state == S_RUN) && adv;
  assign q_pop       = (state == S_IDLE) && q_valid;
  assign release_row = issue && (k == last_idx);
  assign ram_re      = adv;
  assign ram_raddr   = {bank, k};

  assign {r_grad, r_prob, r_prev} = ram_rdata;

  assign diff_c = $signed({{(ACC_W - GRAD_W - FRAC_W){r_grad[GRAD_W-1]}}, r_grad,
                           {FRAC_W{1'b0}}}) - dot1;
  assign prod_c = PMUL_W'(diff2) * PMUL_W'($signed({1'b0, prob2}));
  assign rnd_c  = prod3 + ROUND_HALF;
  assign sum_c  = SUM_W'(prev4) + SUM_W'(term4);

  // clip when the bits above the result's sign disagree with it
  assign sum_hi  = sum_c[SUM_W-1:PREV_W-1];
  assign ovf     = !((&sum_hi) || !(|sum_hi));
  assign sat_val = sum_c[SUM_W-1] ? {1'b1, {(PREV_W-1){1'b0}}} : {1'b0, {(PREV_W-1){1'b1}}};

  always_ff @(posedge clk) begin
    if (q_pop) begin
      bank     <= q_bank;
      last_idx <= q_last_idx;
      dot      <= q_dot;
    end
    if (adv) begin
      last1 <= (k == last_idx);
      dot1  <= dot;
      last2 <= last1;
      diff2 <= diff_c[DIFF_W-1:0];
      prob2 <= r_prob;
      prev2 <= r_prev;
      last3 <= last2;
      prod3 <= prod_c[PROD_W-1:0];
      prev3 <= prev2;
      last4 <= last3;
      term4 <= rnd_c[PROD_W-1:2*FRAC_W];
      prev4 <= prev3;
      dout.new_grad <= ovf ? sat_val : sum_c[PREV_W-1:0];
      dout.sat_flag <= ovf;
      dout.out_last <= last4;
    end
    if (rst) begin
      state      <= S_IDLE;
      k          <= '0;
      v1         <= 1'b0;
      v2         <= 1'b0;
      v3         <= 1'b0;
      v4         <= 1'b0;
      dout.valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            state <= S_RUN;
            k     <= '0;
          end
        end
        S_RUN: begin
          if (adv) begin
            if (k == last_idx) begin
              state <= S_IDLE;
            end else begin
              k <= k + CW'(1);
            end
          end
        end
        default: state <= S_IDLE;
      endcase
      if (adv) begin
        v1         <= issue;
        v2         <= v1;
        v3         <= v2;
        v4         <= v3;
        dout.valid <= v4;
      end
    end
  end

`ifndef ASSERT_OFF
  a_release_marks_last: assert property (@(posedge clk) disable iff (rst)
    release_row |=> v1 && last1)
    else $error("row released without its last element in flight");

  a_pop_starts_row: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> state == S_RUN && k == '0)
    else $error("job pop did not start a row at element zero");

  a_no_pop_while_run: assert property (@(posedge clk) disable iff (rst)
    state == S_RUN |-> !q_pop)
    else $error("job popped while a row is still issuing");
`endif

endmodule

`default_nettype wire

[hdl/softmax_gradient_row_top.sv]
// Softmax backward pass over one row at a time, Q3.12 fixed point.
// Depends on sgr_pkg, sgr_in_if/sgr_out_if, sgr_ram, sgr_job_q, sgr_front, sgr_back.
//
//   channel  dir  fields                                         handshake
//   din      in   grad_elem, prob_elem, prev_elem, row_last      valid/ready
//   dout     out  new_grad, sat_flag, out_last                   valid/ready
//
// The front takes one element per cycle while a row buffer bank is free;
// two banks let one row load while the previous one is emitted.
// A closed row is queued as a job; the back part reads it out and gives
// one result per cycle while dout does not stall, after a five-stage pipeline.
// Reset is synchronous; the row buffer needs no clearing pass.
// A stall on dout freezes only the back pipeline; the front loads while a bank is free.
`default_nettype none

module softmax_gradient_row_top import sgr_pkg::*; #(
  parameter int MAX_COLS = MAX_COLS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  sgr_in_if.sink    din,
  sgr_out_if.source dout
);

  localparam int CW    = $clog2(MAX_COLS);
  localparam int AW    = CW + 1;
  localparam int JOB_W = 1 + CW + ACC_W;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [ELEM_W-1:0] ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [ELEM_W-1:0] ram_rdata;

  logic              q_push;
  logic [ACC_W-1:0]  f_dot;
  logic              f_bank;
  logic [CW-1:0]     f_last_idx;
  logic              q_pop;
  logic              q_valid;
  logic [ACC_W-1:0]  b_dot;
  logic              b_bank;
  logic [CW-1:0]     b_last_idx;
  logic              release_row;

  sgr_ram #(
    .WIDTH (ELEM_W),
    .DEPTH (2 ** AW)
  ) u_row_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  sgr_front #(
    .MAX_COLS (MAX_COLS),
    .CW       (CW),
    .AW       (AW)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .din         (din),
    .release_row (release_row),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .q_push      (q_push),
    .q_dot       (f_dot),
    .q_bank      (f_bank),
    .q_last_idx  (f_last_idx)
  );

  sgr_job_q #(
    .WIDTH (JOB_W),
    .DEPTH (JOBQ_DEPTH)
  ) u_job_q (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data ({f_bank, f_last_idx, f_dot}),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_data  ({b_bank, b_last_idx, b_dot})
  );

  sgr_back #(
    .CW (CW),
    .AW (AW)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_dot       (b_dot),
    .q_bank      (b_bank),
    .q_last_idx  (b_last_idx),
    .q_pop       (q_pop),
    .release_row (release_row),
    .ram_re      (ram_re),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata),
    .dout        (dout)
  );

endmodule

`default_nettype wire

[test/tb_softmax_gradient_row_top.sv]
// Self-checking bench for softmax_gradient_row_top: directed rows, then random rows.
// Every result is predicted from the accepted elements and checked in order.
// Depends on sgr_pkg, the sgr_in_if/sgr_out_if channels and the block's RTL.
`default_nettype none

module tb_softmax_gradient_row_top;
  import sgr_pkg::*;

  localparam int ROW_MAX      = MAX_COLS_DEF;
  localparam int RANDOM_ITEMS = 240;
  localparam int DRAIN_CYCLES = 40;
  localparam int N_DIRECTED   = 18;
  localparam longint ROUND_Q24 = longint'(1) <<< (2 * FRAC_W - 1);
  localparam longint GRAD_MAXV = 32767;
  localparam longint GRAD_MINV = -32768;

  typedef struct packed {
    logic signed [GRAD_W-1:0] grad;
    logic        [PROB_W-1:0] prob;
    logic signed [PREV_W-1:0] prev;
    logic                     last;
  } elem_t;

  typedef struct packed {
    elem_t                    elem;
    logic                     typed;
    logic signed [PREV_W-1:0] want_grad;
    logic                     want_sat;
  } stim_row_t;

  typedef struct packed {
    logic signed [PREV_W-1:0] new_grad;
    logic                     sat_flag;
    logic                     out_last;
  } grad_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sgr_in_if  din ();
  sgr_out_if dout ();

  softmax_gradient_row_top dut (
    .clk (clk),
    .rst (rst),
    .din (din),
    .dout(dout)
  );

  always #2 clk = ~clk;

  // Single-element rows with prob 0 or 1.0 give prev back unchanged; the
  // half-scale extremes overflow and clip.
  stim_row_t directed_rows [N_DIRECTED] = '{
    '{'{16'sh0000, 13'd0,    16'sh0000, 1'b1}, 1'b1, 16'sh0000, 1'b0},
    '{'{16'sh7FFF, 13'd4096, 16'sh8000, 1'b1}, 1'b1, 16'sh8000, 1'b0},
    '{'{16'sh8000, 13'd4096, 16'sh7FFF, 1'b1}, 1'b1, 16'sh7FFF, 1'b0},
    '{'{16'sh8000, 13'd0,    16'sh3039, 1'b1}, 1'b1, 16'sh3039, 1'b0},
    '{'{16'sh7FFF, 13'd2048, 16'sh7FFF, 1'b1}, 1'b1, 16'sh7FFF, 1'b1},
    '{'{16'sh8000, 13'd2048, 16'sh8000, 1'b1}, 1'b1, 16'sh8000, 1'b1},
    // rounding ties: +0.5 goes up, -0.5 goes to zero
    '{'{16'sh0002, 13'd2048, 16'sh0000, 1'b1}, 1'b0, 16'sh0000, 1'b0},
    '{'{16'shFFFE, 13'd2048, 16'sh0000, 1'b1}, 1'b0, 16'sh0000, 1'b0},
    // probability above one, then rows of several elements
    '{'{16'sh1000, 13'd8191, 16'sh0000, 1'b1}, 1'b0, 16'sh0000, 1'b0},
    '{'{16'sh1000, 13'd1000, 16'sh0100, 1'b0}, 1'b0, 16'sh0000, 1'b0},
    '{'{16'shF000, 13'd2000, 16'shFF00, 1'b0}, 1'b0, 16'sh0000, 1'b0},
    '{'{16'sh0800, 13'd1096, 16'sh1234, 1'b1}, 1'b0, 16'sh0000, 1'b0},
    '{'{16'sh7FFF, 13'd8191, 16'sh7FFF, 1'b0}, 1'b0, 16'sh0000, 1'b0},
    '{'{16'sh8000, 13'd8191, 16'sh8000, 1'b1}, 1'b0, 16'sh0000, 1'b0},
    '{'{16'sh5555, 13'd1024, 16'shAAAA, 1'b0}, 1'b0, 16'sh0000, 1'b0},
    '{'{16'shAAAA, 13'd1024, 16'sh5555, 1'b0}, 1'b0, 16'sh0000, 1'b0},
    '{'{16'sh0001, 13'd1024, 16'sh7FFF, 1'b0}, 1'b0, 16'sh0000, 1'b0},
    '{'{16'shFFFF, 13'd1024, 16'sh8000, 1'b1}, 1'b0, 16'sh0000, 1'b0}
  };

  // Row buffer and dot product of the predictor
  logic signed [GRAD_W-1:0] row_grad_mem [ROW_MAX];
  logic        [PROB_W-1:0] row_prob_mem [ROW_MAX];
  logic signed [PREV_W-1:0] row_prev_mem [ROW_MAX];
  longint                   dot_q24;
  int                       row_fill;

  grad_result_t expected_grads [$];

  bit src_idle;
  bit snk_idle;
  int err_count;
  int elems_sent;
  int rows_closed;
  int full_rows;
  int results_seen;
  int sat_seen;

  // Store one accepted element; on row close, queue a result per element.
  task automatic fold_elem(input elem_t e);
    longint gl, pl, vl, diff, prod, term, total;
    grad_result_t r;
    int k;
    row_grad_mem[row_fill] = e.grad;
    row_prob_mem[row_fill] = e.prob;
    row_prev_mem[row_fill] = e.prev;
    gl = longint'(e.grad);
    pl = longint'(e.prob);
    dot_q24 += gl * pl;
    row_fill++;
    if (!e.last && row_fill < ROW_MAX) return;
    if (!e.last) full_rows++;
    rows_closed++;
    for (k = 0; k < row_fill; k++) begin
      gl = longint'(row_grad_mem[k]);
      pl = longint'(row_prob_mem[k]);
      vl = longint'(row_prev_mem[k]);
      diff = (gl <<< FRAC_W) - dot_q24;
      prod = diff * pl;
      term = (prod + ROUND_Q24) >>> (2 * FRAC_W);
      total = vl + term;
      r.sat_flag = 1'b0;
      if (total > GRAD_MAXV) begin
        total = GRAD_MAXV;
        r.sat_flag = 1'b1;
      end else if (total < GRAD_MINV) begin
        total = GRAD_MINV;
        r.sat_flag = 1'b1;
      end
      r.new_grad = total[PREV_W-1:0];
      r.out_last = (k == row_fill - 1);
      expected_grads.push_back(r);
    end
    dot_q24 = 0;
    row_fill = 0;
  endtask

  task automatic send_elem(input elem_t e);
    int gap;
    gap = src_idle ? $urandom_range(0, 7) : 0;
    @(negedge clk);
    if (gap > 0) begin
      din.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    din.valid     <= 1'b1;
    din.grad_elem <= e.grad;
    din.prob_elem <= e.prob;
    din.prev_elem <= e.prev;
    din.row_last  <= e.last;
    @(posedge clk);
    while (!din.ready) @(posedge clk);
    fold_elem(e);
    elems_sent++;
  endtask

  // Result side: random stall before each transfer while snk_idle is set
  initial begin
    int stall;
    dout.ready = 1'b0;
    wait (rst == 1'b0);
    forever begin
      stall = snk_idle ? $urandom_range(0, 7) : 0;
      @(negedge clk);
      if (stall > 0) begin
        dout.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      dout.ready <= 1'b1;
      @(posedge clk);
      while (!dout.valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    grad_result_t want;
    if (!rst && dout.valid && dout.ready) begin
      results_seen++;
      if (dout.sat_flag) sat_seen++;
      if (expected_grads.size() == 0) begin
        $error("unexpected result: new_grad %0d sat_flag %0d out_last %0d",
               dout.new_grad, dout.sat_flag, dout.out_last);
        err_count++;
      end else begin
        want = expected_grads.pop_front();
        if (dout.new_grad !== want.new_grad) begin
          $error("new_grad mismatch: expected %0d, actual %0d", want.new_grad, dout.new_grad);
          err_count++;
        end
        if (dout.sat_flag !== want.sat_flag) begin
          $error("sat_flag mismatch: expected %0d, actual %0d", want.sat_flag, dout.sat_flag);
          err_count++;
        end
        if (dout.out_last !== want.out_last) begin
          $error("out_last mismatch: expected %0d, actual %0d", want.out_last, dout.out_last);
          err_count++;
        end
      end
    end
  end

  initial begin
    #200000;
    $display("tb_softmax_gradient_row_top failed");
    $finish;
  end

  initial begin
    elem_t e;
    int i, k, len, budget, random_sent, row_no;
    bit shaped;
    din.valid     = 1'b0;
    din.grad_elem = '0;
    din.prob_elem = '0;
    din.prev_elem = '0;
    din.row_last  = 1'b0;
    dot_q24  = 0;
    row_fill = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (i = 0; i < N_DIRECTED; i++) begin
      src_idle = 1'($urandom_range(0, 1));
      snk_idle = 1'($urandom_range(0, 1));
      send_elem(directed_rows[i].elem);
      // typed rows are single-element rows: their one result is known by hand
      if (directed_rows[i].typed)
        expected_grads[expected_grads.size() - 1] =
          '{directed_rows[i].want_grad, directed_rows[i].want_sat, 1'b1};
    end

    // First two rows run to full length, closed by count and by row_last.
    random_sent = 0;
    row_no = 0;
    while (random_sent < RANDOM_ITEMS) begin
      if (row_no < 2 || $urandom_range(0, 9) == 0) len = ROW_MAX;
      else len = $urandom_range(1, 10);
      shaped   = 1'($urandom_range(0, 1));
      budget   = 1 << FRAC_W;
      src_idle = $urandom_range(0, 3) != 0;
      snk_idle = $urandom_range(0, 3) != 0;
      for (k = 0; k < len; k++) begin
        case ($urandom_range(0, 7))
          0:       e.grad = 16'sh7FFF;
          1:       e.grad = 16'sh8000;
          2:       e.grad = GRAD_W'($urandom_range(0, 8191) - 4096);
          default: e.grad = GRAD_W'($urandom);
        endcase
        // shaped rows hold probabilities that sum to one
        if (shaped) begin
          e.prob = PROB_W'((k == len - 1) ? budget : $urandom_range(0, budget));
          budget -= int'(e.prob);
        end else if ($urandom_range(0, 3) == 0) begin
          e.prob = PROB_W'($urandom_range(0, 8191));
        end else begin
          e.prob = PROB_W'($urandom_range(0, 1 << FRAC_W));
        end
        e.prev = PREV_W'($urandom);
        e.last = 1'b0;
        if (k == len - 1) begin
          if (len < ROW_MAX || row_no == 1) e.last = 1'b1;
          else if (row_no > 1) e.last = 1'($urandom_range(0, 1));
        end
        send_elem(e);
        random_sent++;
      end
      row_no++;
    end

    @(negedge clk);
    din.valid <= 1'b0;
    while (expected_grads.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d elements in %0d rows, %0d of them closed at %0d without row_last",
             elems_sent, rows_closed, full_rows, ROW_MAX);
    $display("checked %0d results, %0d saturated", results_seen, sat_seen);
    if (err_count == 0) begin
      $display("tb_softmax_gradient_row_top passed");
    end else begin
      $display("tb_softmax_gradient_row_top failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
